### src/afr_pkg.sv
`default_nettype none

package afr_pkg;

    // Field and register widths
    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned GAIN_BITS   = 8;
    localparam int unsigned STEP_BITS   = 24;
    localparam int unsigned CFG_IDX_BITS = 2;

    // Defaults for the top-level parameters
    localparam int unsigned FULL_LEVEL_DEF = 128;
    localparam int unsigned COUNT_BITS_DEF = 24;

    // Offset-binary midpoint for 8-bit samples
    localparam logic [7:0] BYTE_SIGN_FLIP = 8'h80;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FADE_DIRECTION = 2'd0,
        CFG_WIDE_SAMPLES   = 2'd1,
        CFG_LEVEL_STEP     = 2'd2
    } cfg_index_t;

endpackage

`default_nettype wire

### src/audio_fade_ramp.sv
`default_nettype none
// Linear volume fade: scales each sample by gain_level / FULL_LEVEL.
// Pipeline: the input, product and result registers load in turn after the input transaction;
// throughput 1 sample per cycle while m_ready stays high, since every stage advances
// whenever it is empty or the stage after it does.
// The divide by FULL_LEVEL is an exact reciprocal multiply in the second stage.
// Reset (aresetn low, synchronous): fade-out, 8-bit mode, step 0, gain at FULL_LEVEL,
// sample counter cleared, pipeline empty.
module audio_fade_ramp #(
    parameter int unsigned FULL_LEVEL = afr_pkg::FULL_LEVEL_DEF,
    parameter int unsigned COUNT_BITS = afr_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [afr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [afr_pkg::STEP_BITS-1:0]     cfg_wdata,
    // sample input
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [afr_pkg::SAMPLE_BITS-1:0]   s_sample_in,
    // sample output
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [afr_pkg::SAMPLE_BITS-1:0]        m_sample_out
);
    import afr_pkg::*;

    localparam int unsigned PROD_BITS  = SAMPLE_BITS + GAIN_BITS;
    localparam int unsigned SHIFT      = PROD_BITS + $clog2(FULL_LEVEL);
    localparam int unsigned RECIP_BITS = PROD_BITS + 1;
    localparam int unsigned WIDE_BITS  = PROD_BITS + RECIP_BITS;
    localparam int unsigned CMP_BITS   = (COUNT_BITS > STEP_BITS) ? COUNT_BITS : STEP_BITS;
    // ceil(2^SHIFT / FULL_LEVEL): exact floor division for any PROD_BITS-bit product
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(FULL_LEVEL) - 64'd1) / 64'(FULL_LEVEL);
    localparam logic [RECIP_BITS-1:0] RECIP_K   = RECIP[RECIP_BITS-1:0];
    localparam logic [GAIN_BITS-1:0]  FULL_GAIN = GAIN_BITS'(FULL_LEVEL);

    // configuration and fade state
    logic                    fade_dir_reg;
    logic                    wide_reg;
    logic [STEP_BITS-1:0]    step_reg;
    logic [GAIN_BITS-1:0]    gain_reg, gain_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;

    // pipeline registers
    logic                    s1_valid_reg;
    logic [SAMPLE_BITS-1:0]  s1_sample_reg;
    logic                    s1_wide_reg;
    logic [GAIN_BITS-1:0]    s1_gain_reg;
    logic                    s2_valid_reg;
    logic [PROD_BITS-1:0]    s2_prod_reg;
    logic                    s2_neg_reg;
    logic                    s2_wide_reg;
    logic                    m_valid_reg;
    logic [SAMPLE_BITS-1:0]  m_sample_reg;

    logic                    out_en, s2_en, s1_en, in_fire;

    // stall chain: a stage moves when it is empty or its successor moves
    assign out_en  = !m_valid_reg || m_ready;
    assign s2_en   = !s2_valid_reg || out_en;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign s_ready = s1_en;
    assign in_fire = s_valid && s1_en;

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

    // counter and gain ramp, advanced once per input transaction without a register write
    logic [COUNT_BITS-1:0] count_inc;
    always_comb begin
        count_inc  = (count_reg == {COUNT_BITS{1'b1}}) ? count_reg : count_reg + 1'b1;
        count_next = count_inc;
        gain_next  = gain_reg;
        if (CMP_BITS'(count_inc) >= CMP_BITS'(step_reg)) begin
            count_next = '0;
            if (fade_dir_reg) begin
                if (gain_reg != '0) gain_next = gain_reg - 1'b1;
            end else begin
                if (gain_reg < FULL_GAIN) gain_next = gain_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_dir_reg <= 1'b1;
            wide_reg     <= 1'b0;
            step_reg     <= '0;
            gain_reg     <= FULL_GAIN;
            count_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FADE_DIRECTION: begin
                    fade_dir_reg <= cfg_wdata[0];
                    gain_reg     <= cfg_wdata[0] ? FULL_GAIN : '0;
                    count_reg    <= '0;
                end
                CFG_WIDE_SAMPLES: wide_reg <= cfg_wdata[0];
                CFG_LEVEL_STEP:   step_reg <= cfg_wdata;
                default: ;
            endcase
        end else if (in_fire) begin
            gain_reg  <= gain_next;
            count_reg <= count_next;
        end
    end

    // stage 1: sign handling and sample x gain
    logic [7:0]             s1_flip;
    logic [SAMPLE_BITS-1:0] s1_signed, s1_mag;
    logic [PROD_BITS-1:0]   s1_prod;
    always_comb begin
        s1_flip   = s1_sample_reg[7:0] ^ BYTE_SIGN_FLIP;
        s1_signed = s1_wide_reg ? s1_sample_reg : {{(SAMPLE_BITS-8){s1_flip[7]}}, s1_flip};
        s1_mag    = s1_signed[SAMPLE_BITS-1] ? (~s1_signed + 1'b1) : s1_signed;
        s1_prod   = PROD_BITS'(s1_mag) * PROD_BITS'(s1_gain_reg);
    end

    // stage 2: divide magnitude by FULL_LEVEL, restore sign and encoding
    logic [WIDE_BITS-1:0]   s2_wide_prod;
    logic [SAMPLE_BITS-1:0] s2_quot, s2_res, s2_out;
    always_comb begin
        s2_wide_prod = WIDE_BITS'(s2_prod_reg) * WIDE_BITS'(RECIP_K);
        s2_quot      = SAMPLE_BITS'(s2_wide_prod >> SHIFT);
        s2_res       = s2_neg_reg ? (SAMPLE_BITS'(0) - s2_quot) : s2_quot;
        s2_out       = s2_wide_reg ? s2_res
                                   : {{(SAMPLE_BITS-8){1'b0}}, s2_res[7:0] ^ BYTE_SIGN_FLIP};
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_en) s1_valid_reg <= s_valid;
            if (s2_en) s2_valid_reg <= s1_valid_reg;
            if (out_en) m_valid_reg <= s2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_sample_reg <= s_sample_in;
            s1_wide_reg   <= wide_reg;
            s1_gain_reg   <= gain_reg;
        end
        if (s2_en && s1_valid_reg) begin
            s2_prod_reg <= s1_prod;
            s2_neg_reg  <= s1_signed[SAMPLE_BITS-1];
            s2_wide_reg <= s1_wide_reg;
        end
        if (out_en && s2_valid_reg) begin
            m_sample_reg <= s2_out;
        end
    end

endmodule

`default_nettype wire

### tb/sv/audio_fade_ramp_test.sv
`default_nettype none

module audio_fade_ramp_test;
    import afr_pkg::*;

    localparam int FULL       = int'(FULL_LEVEL_DEF);
    localparam int CNT_BITS   = int'(COUNT_BITS_DEF);
    localparam int LATENCY    = 3;
    localparam int NUM_PHASES = 12;
    localparam int HOLD_AT    = 500;   // result count after which the long receiver hold starts
    localparam int HOLD_LEN   = 250;
    localparam int HOLD_BACKLOG = 8;   // queued samples needed so the block backs up

    // register index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REG = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_in;
        logic [SAMPLE_BITS-1:0] sample_out;
    } faded_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [STEP_BITS-1:0]    cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [SAMPLE_BITS-1:0]  s_sample_in = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [SAMPLE_BITS-1:0]  m_sample_out;

    logic [SAMPLE_BITS-1:0]  pending_samples[$];
    faded_t                  expected_faded[$];
    int                      errors = 0;
    int                      results_seen = 0;
    bit                      idle_on = 1'b1;

    // ramp state and register copies
    bit                      ramp_fade_out;
    bit                      ramp_wide;
    logic [STEP_BITS-1:0]    ramp_step;
    int                      ramp_gain;
    logic [CNT_BITS-1:0]     ramp_count;

    audio_fade_ramp u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    always #1 aclk = ~aclk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 80) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // scale one sample by the current level, then advance counter and level
    function automatic logic [SAMPLE_BITS-1:0] fade_and_step(logic [SAMPLE_BITS-1:0] raw);
        int s;
        int q;
        logic [SAMPLE_BITS-1:0] res;
        if (ramp_wide) begin
            s = $signed(raw);
            q = (s * ramp_gain) / FULL;
            res = q[15:0];
        end else begin
            s = $signed(raw[7:0] ^ BYTE_SIGN_FLIP);
            q = (s * ramp_gain) / FULL;
            res = {8'h00, q[7:0] ^ BYTE_SIGN_FLIP};
        end
        if (ramp_count != '1) ramp_count = ramp_count + 1'b1;
        if (ramp_count >= ramp_step) begin
            if (ramp_fade_out) begin
                if (ramp_gain > 0) ramp_gain = ramp_gain - 1;
            end else begin
                if (ramp_gain < FULL) ramp_gain = ramp_gain + 1;
            end
            ramp_count = '0;
        end
        return res;
    endfunction

    // register write, mirrored into the ramp copy
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [STEP_BITS-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_FADE_DIRECTION: begin
                ramp_fade_out = data[0];
                ramp_gain     = data[0] ? FULL : 0;
                ramp_count    = '0;
            end
            CFG_WIDE_SAMPLES: ramp_wide = data[0];
            CFG_LEVEL_STEP:   ramp_step = data;
            default: ;
        endcase
    endtask

    // hold the sender until every result is back, then let the pipeline settle
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_valid || expected_faded.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // driver: offers queued samples, predicts on each accepted transaction
    always @(posedge aclk) begin : drive_proc
        int     gap_left;
        bit     fire;
        faded_t exp_item;
        fire = s_valid && s_ready;
        if (fire) begin
            exp_item.sample_in  = s_sample_in;
            exp_item.sample_out = fade_and_step(s_sample_in);
            expected_faded.push_back(exp_item);
        end
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else if (!s_valid || fire) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s_valid     <= 1'b1;
                s_sample_in <= pending_samples.pop_front();
                gap_left    = idle_on ? pick_gap() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: checks results in order and drives the receiver stalls
    always @(posedge aclk) begin : mon_proc
        int     stall_left;
        int     hold_left;
        bit     hold_done;
        faded_t exp_item;
        if (m_valid && m_ready) begin
            results_seen = results_seen + 1;
            if (expected_faded.size() == 0) begin
                errors = errors + 1;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_sample_out);
            end else begin
                exp_item = expected_faded.pop_front();
                if (m_sample_out !== exp_item.sample_out) begin
                    errors = errors + 1;
                    $display("%0t: sample_out mismatch for input %h, expected %h, actual %h",
                             $time, exp_item.sample_in, exp_item.sample_out, m_sample_out);
                end
            end
        end
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end else begin
            // one long hold, started while the sender still has a backlog to push
            if (results_seen >= HOLD_AT && !hold_done &&
                pending_samples.size() > HOLD_BACKLOG) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // stimulus
    initial begin : stim_proc
        int                   n_items;
        int                   r;
        logic [STEP_BITS-1:0] step_val;
        logic [SAMPLE_BITS-1:0] smp;

        ramp_fade_out = 1'b1;
        ramp_wide     = 1'b0;
        ramp_step     = '0;
        ramp_gain     = FULL;
        ramp_count    = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset settings: 8-bit fade-out, step of zero moves the level every sample
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'h00FF);
        pending_samples.push_back(16'h0080);
        pending_samples.push_back(16'h007F);
        pending_samples.push_back(16'hFF00);   // high byte ignored in 8-bit mode
        pending_samples.push_back(16'hA501);
        wait_drained();

        // 16-bit signed extremes
        write_reg(CFG_WIDE_SAMPLES, 24'h000001);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h7FFF);
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'h0001);
        wait_drained();

        // direction write reloads full level
        write_reg(CFG_FADE_DIRECTION, 24'h000001);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h7FFF);
        wait_drained();

        // fade-in from zero level
        write_reg(CFG_FADE_DIRECTION, 24'h000000);
        write_reg(CFG_LEVEL_STEP, 24'h000002);
        pending_samples.push_back(16'h7FFF);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h1234);
        wait_drained();

        // counter above a newly lowered step fires on the next sample
        write_reg(CFG_LEVEL_STEP, 24'h00000A);
        repeat (5) pending_samples.push_back(16'($urandom));
        wait_drained();
        write_reg(CFG_LEVEL_STEP, 24'h000003);
        write_reg(CFG_NO_REG, 24'hFFFFFF);     // no register there, ignored
        pending_samples.push_back(16'h4000);
        pending_samples.push_back(16'hC000);
        wait_drained();

        // random phases, each with its own settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0) step_val = 24'hFFFFFF;
            else if (ph == 1) step_val = 24'h000000;
            else begin
                r = $urandom_range(0, 9);
                if (r < 5) step_val = 24'($urandom_range(0, 3));
                else if (r < 8) step_val = 24'($urandom_range(4, 40));
                else if (r < 9) step_val = 24'($urandom_range(41, 300));
                else step_val = 24'($urandom);
            end
            if (ph < 2 || $urandom_range(0, 2) != 0)
                write_reg(CFG_FADE_DIRECTION, 24'($urandom));
            write_reg(CFG_WIDE_SAMPLES, 24'($urandom));
            write_reg(CFG_LEVEL_STEP, step_val);
            if ($urandom_range(0, 3) == 0) write_reg(CFG_NO_REG, 24'($urandom));
            idle_on = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);

            n_items = $urandom_range(70, 130);
            for (int i = 0; i < n_items; i++) begin
                case ($urandom_range(0, 19))
                    0: smp = 16'h0000;
                    1: smp = 16'hFFFF;
                    2: smp = 16'h8000;
                    3: smp = 16'h7FFF;
                    4: smp = {8'($urandom), 8'h80};
                    5: smp = {8'($urandom), 8'h7F};
                    default: smp = 16'($urandom);
                endcase
                pending_samples.push_back(smp);
            end
            wait_drained();
        end

        if (expected_faded.size() != 0) begin
            errors = errors + 1;
            $display("%0t: results missing, expected %0d more, actual 0", $time,
                     expected_faded.size());
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog_proc
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
